FILE: hdl/jsesc_pkg.sv
// Shared types, character codes and helpers for the JSON string escaper.
// Used by jsesc_front, jsesc_fifo, jsesc_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package jsesc_pkg;

   // command queue between the front and back parts
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);

   // characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LOW_A  = 8'h61;

   // raw bytes that get a short escape
   localparam logic [7:0] BYTE_BS  = 8'h08;
   localparam logic [7:0] BYTE_FF  = 8'h0C;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_TAB = 8'h09;

   // UTF-8 lead and continuation limits
   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] LEAD_SURR = 8'hED;
   localparam logic [7:0] CONT_A0  = 8'hA0;
   localparam logic [7:0] CONT_90  = 8'h90;
   localparam logic [7:0] CONT_8F  = 8'h8F;
   localparam logic [20:0] CP_BMP_MAX = 21'h00FFFF;

   // one command: optional opening quote, up to four literal bytes
   // (left-aligned), up to eight hex digits (left-aligned), optional error
   typedef struct packed {
      logic        open_q;
      logic [2:0]  raw_len;
      logic [31:0] raw;
      logic [3:0]  hex_len;
      logic [31:0] hex;
      logic        err;
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) c = CH_ZERO + {4'b0, d};
      else c = CH_LOW_A + {4'b0, d} - 8'd10;
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/jsesc_front.sv
// Front part: takes string bytes, tracks UTF-8 state and turns each item into
// at most one output command. Depends on jsesc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jsesc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             accept,
   input  wire logic [7:0]       content_byte,
   input  wire logic             end_of_string,
   output jsesc_pkg::cmd_type    cmd,
   output logic                  cmd_valid
);
   import jsesc_pkg::*;

   logic        ascii_only_ff;
   logic        in_string_ff, in_string_in;
   logic        rejected_ff, rejected_in;
   logic [7:0]  lead_ff, lead_in;
   logic [15:0] pend_ff, pend_in;
   logic [1:0]  need_ff, need_in;
   logic [1:0]  have_ff, have_in;

   logic        e_rej;
   logic [1:0]  e_need, e_have;
   logic [7:0]  e_lead;
   logic [15:0] e_pend;
   logic [7:0]  esc;
   logic [20:0] cp;
   logic [7:0]  b;
   logic        bad_first;

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_only_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ascii_only_ff <= csr_wr_data;
      end
   end

   always_comb begin
      b = content_byte;
      // a new string starts from a clean sequence state
      e_rej  = in_string_ff & rejected_ff;
      e_need = in_string_ff ? need_ff : 2'd0;
      e_have = in_string_ff ? have_ff : 2'd0;
      e_lead = in_string_ff ? lead_ff : 8'd0;
      e_pend = in_string_ff ? pend_ff : 16'd0;

      unique case (b)
         CH_QUOTE:  esc = CH_QUOTE;
         CH_BSLASH: esc = CH_BSLASH;
         BYTE_BS:   esc = CH_B;
         BYTE_FF:   esc = CH_F;
         BYTE_LF:   esc = CH_N;
         BYTE_CR:   esc = CH_R;
         BYTE_TAB:  esc = CH_T;
         default:   esc = 8'd0;
      endcase

      bad_first = (e_have == 2'd0) &&
                  ((e_lead == LEAD3_LO && b < CONT_A0) ||
                   (e_lead == LEAD_SURR && b >= CONT_A0) ||
                   (e_lead == LEAD4_LO && b < CONT_90) ||
                   (e_lead == LEAD4_HI && b > CONT_8F));

      case (e_need)
         2'd1:    cp = {10'd0, e_lead[4:0], b[5:0]};
         2'd2:    cp = {5'd0, e_lead[3:0], e_pend[5:0], b[5:0]};
         default: cp = {e_lead[2:0], e_pend[13:8], e_pend[5:0], b[5:0]};
      endcase

      cmd = '0;
      cmd.open_q   = ~in_string_ff;
      in_string_in = 1'b1;
      rejected_in  = e_rej;
      lead_in      = e_lead;
      pend_in      = e_pend;
      need_in      = e_need;
      have_in      = e_have;

      if (end_of_string) begin
         if (!e_rej) begin
            if (e_need != 2'd0) begin
               cmd.err = 1'b1;
            end else begin
               cmd.raw_len = 3'd1;
               cmd.raw     = {CH_QUOTE, 24'd0};
            end
         end
         in_string_in = 1'b0;
         rejected_in  = 1'b0;
         lead_in = 8'd0; pend_in = 16'd0; need_in = 2'd0; have_in = 2'd0;
      end else if (e_rej) begin
         // dropped
      end else if (e_need == 2'd0) begin
         if (!b[7]) begin
            if (esc != 8'd0) begin
               cmd.raw_len = 3'd2;
               cmd.raw     = {CH_BSLASH, esc, 16'd0};
            end else if (b < 8'h20) begin
               cmd.raw_len = 3'd2;
               cmd.raw     = {CH_BSLASH, CH_LOW_U, 16'd0};
               cmd.hex_len = 4'd4;
               cmd.hex     = {8'd0, b, 16'd0};
            end else begin
               cmd.raw_len = 3'd1;
               cmd.raw     = {b, 24'd0};
            end
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            lead_in = b; need_in = 2'd1; have_in = 2'd0; pend_in = 16'd0;
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            lead_in = b; need_in = 2'd2; have_in = 2'd0; pend_in = 16'd0;
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            lead_in = b; need_in = 2'd3; have_in = 2'd0; pend_in = 16'd0;
         end else begin
            cmd.err = 1'b1;
            rejected_in = 1'b1;
         end
      end else if (b[7:6] != 2'b10 || bad_first) begin
         cmd.err = 1'b1;
         rejected_in = 1'b1;
         lead_in = 8'd0; pend_in = 16'd0; need_in = 2'd0; have_in = 2'd0;
      end else if ({1'b0, e_have} + 3'd1 < {1'b0, e_need}) begin
         pend_in = {e_pend[7:0], b};
         have_in = e_have + 2'd1;
      end else begin
         // sequence complete
         if (ascii_only_ff) begin
            cmd.raw_len = 3'd2;
            if (cp <= CP_BMP_MAX) begin
               cmd.raw     = {CH_BSLASH, CH_LOW_U, 16'd0};
               cmd.hex_len = 4'd4;
               cmd.hex     = {cp[15:0], 16'd0};
            end else begin
               cmd.raw     = {CH_BSLASH, CH_UP_U, 16'd0};
               cmd.hex_len = 4'd8;
               cmd.hex     = {11'd0, cp};
            end
         end else begin
            case (e_need)
               2'd1: begin
                  cmd.raw_len = 3'd2;
                  cmd.raw     = {e_lead, b, 16'd0};
               end
               2'd2: begin
                  cmd.raw_len = 3'd3;
                  cmd.raw     = {e_lead, e_pend[7:0], b, 8'd0};
               end
               default: begin
                  cmd.raw_len = 3'd4;
                  cmd.raw     = {e_lead, e_pend, b};
               end
            endcase
         end
         lead_in = 8'd0; pend_in = 16'd0; need_in = 2'd0; have_in = 2'd0;
      end

      cmd_valid = accept & (cmd.open_q | (cmd.raw_len != 3'd0) | cmd.err);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         rejected_ff  <= 1'b0;
         lead_ff      <= 8'd0;
         pend_ff      <= 16'd0;
         need_ff      <= 2'd0;
         have_ff      <= 2'd0;
      end else if (accept) begin
         in_string_ff <= in_string_in;
         rejected_ff  <= rejected_in;
         lead_ff      <= lead_in;
         pend_ff      <= pend_in;
         need_ff      <= need_in;
         have_ff      <= have_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/jsesc_fifo.sv
// Short command queue between the front and back parts.
// Depends on jsesc_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none
module jsesc_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire jsesc_pkg::cmd_type wr_data,
   input  wire logic             rd_en,
   output jsesc_pkg::cmd_type    rd_data,
   output logic                  empty,
   output logic                  full
);
   import jsesc_pkg::*;

   cmd_type           mem_ff [CMD_DEPTH];
   logic [CMD_AW-1:0] wp_ff, rp_ff;
   logic [CMD_AW:0]   cnt_ff;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == (CMD_AW+1)'(CMD_DEPTH));
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         case ({wr_en, rd_en})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/jsesc_back.sv
// Back part: expands one command into output characters in the result
// register, one per cycle while it is empty or popped. Depends on jsesc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jsesc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire jsesc_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   input  wire logic             pop,
   output logic                  empty,
   output logic [7:0]            out_char,
   output logic                  run_last,
   output logic                  invalid
);
   import jsesc_pkg::*;

   logic        open_ff, open_in;
   logic [2:0]  raw_cnt_ff, raw_cnt_in;
   logic [31:0] raw_sr_ff, raw_sr_in;
   logic [3:0]  hex_cnt_ff, hex_cnt_in;
   logic [31:0] hex_sr_ff, hex_sr_in;
   logic        err_ff, err_in;

   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic        inv_ff, inv_in;

   logic        busy, emit, load, is_last;
   logic        p_open, p_err;
   logic [2:0]  p_raw_cnt;
   logic [31:0] p_raw_sr, p_hex_sr;
   logic [3:0]  p_hex_cnt;
   logic [7:0]  ch;
   logic        ch_inv;

   always_comb begin
      busy = open_ff | (raw_cnt_ff != 3'd0) | (hex_cnt_ff != 4'd0) | err_ff;
      emit = busy & (~valid_ff | pop);

      p_open    = open_ff;
      p_raw_cnt = raw_cnt_ff;
      p_raw_sr  = raw_sr_ff;
      p_hex_cnt = hex_cnt_ff;
      p_hex_sr  = hex_sr_ff;
      p_err     = err_ff;
      ch        = 8'd0;
      ch_inv    = 1'b0;
      // order: opening quote, literal bytes, hex digits, error
      if (open_ff) begin
         ch     = CH_QUOTE;
         p_open = 1'b0;
      end else if (raw_cnt_ff != 3'd0) begin
         ch        = raw_sr_ff[31:24];
         p_raw_sr  = {raw_sr_ff[23:0], 8'd0};
         p_raw_cnt = raw_cnt_ff - 3'd1;
      end else if (hex_cnt_ff != 4'd0) begin
         ch        = hex_char(hex_sr_ff[31:28]);
         p_hex_sr  = {hex_sr_ff[27:0], 4'd0};
         p_hex_cnt = hex_cnt_ff - 4'd1;
      end else begin
         ch_inv = 1'b1;
         p_err  = 1'b0;
      end
      is_last = ~p_open & (p_raw_cnt == 3'd0) & (p_hex_cnt == 4'd0) & ~p_err;

      load    = ~cmd_empty & (~busy | (emit & is_last));
      cmd_pop = load;

      if (load) begin
         open_in    = cmd.open_q;
         raw_cnt_in = cmd.raw_len;
         raw_sr_in  = cmd.raw;
         hex_cnt_in = cmd.hex_len;
         hex_sr_in  = cmd.hex;
         err_in     = cmd.err;
      end else if (emit) begin
         open_in    = p_open;
         raw_cnt_in = p_raw_cnt;
         raw_sr_in  = p_raw_sr;
         hex_cnt_in = p_hex_cnt;
         hex_sr_in  = p_hex_sr;
         err_in     = p_err;
      end else begin
         open_in    = open_ff;
         raw_cnt_in = raw_cnt_ff;
         raw_sr_in  = raw_sr_ff;
         hex_cnt_in = hex_cnt_ff;
         hex_sr_in  = hex_sr_ff;
         err_in     = err_ff;
      end

      if (emit) begin
         valid_in = 1'b1;
         char_in  = ch;
         last_in  = is_last;
         inv_in   = ch_inv;
      end else begin
         valid_in = valid_ff & ~pop;
         char_in  = char_ff;
         last_in  = last_ff;
         inv_in   = inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         raw_cnt_ff <= 3'd0;
         hex_cnt_ff <= 4'd0;
         err_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         open_ff    <= open_in;
         raw_cnt_ff <= raw_cnt_in;
         hex_cnt_ff <= hex_cnt_in;
         err_ff     <= err_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_sr_ff <= raw_sr_in;
      hex_sr_ff <= hex_sr_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      inv_ff    <= inv_in;
   end

   assign empty    = ~valid_ff;
   assign out_char = char_ff;
   assign run_last = last_ff;
   assign invalid  = inv_ff;

endmodule
`default_nettype wire

FILE: hdl/utf8_validating_json_string_escaper.sv
// Top level of the UTF-8 validating JSON string escaper.
// Instantiates jsesc_front, jsesc_fifo and jsesc_back; depends on jsesc_pkg.
//
// Bytes of a string go in one per request, then an end request closes it; out
// come the characters of one quoted JSON string, with an error result in place
// of the rest if the bytes are not valid UTF-8. Each result is one character;
// a request yields 1 character for a plain byte or closing quote, 2 for a
// short escape, up to 4 for a raw UTF-8 sequence, 6 for \uXXXX and 10 for
// \UXXXXXXXX (plus 1 for the opening quote on the first request of a string),
// and some requests yield none. The output character path, one character a
// cycle while pop keeps up, sets the sustained rate. A four-entry command
// queue lets the input keep taking one request per cycle, until it is full,
// while longer expansions drain. ascii_only is written through csr_wr_en /
// csr_wr_data and is taken when a multi-byte sequence completes.
`timescale 1ns / 1ps
`default_nettype none
module utf8_validating_json_string_escaper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_content_byte,
   input  wire logic        req_end_of_string,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_invalid
);
   import jsesc_pkg::*;

   cmd_type front_cmd, q_cmd;
   logic    front_valid, q_empty, q_full, q_pop, accept;

   assign full   = q_full;
   assign accept = push & ~q_full;

   jsesc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .content_byte  (req_content_byte),
      .end_of_string (req_end_of_string),
      .cmd           (front_cmd),
      .cmd_valid     (front_valid)
   );

   jsesc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_cmd),
      .rd_en   (q_pop),
      .rd_data (q_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   jsesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .pop       (pop),
      .empty     (empty),
      .out_char  (rsp_out_char),
      .run_last  (rsp_run_last),
      .invalid   (rsp_invalid)
   );

endmodule
`default_nettype wire
